[rtl/bssp_pkg.sv]
// Shared types, character codes and helper functions for the byte size string parser.
package bssp_pkg;

  // ASCII codes the parser looks at
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam int unsigned UNIT_DEPTH = 3;
  localparam int unsigned ACC_W      = 64;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_DIGIT = 5'b00010,
    PH_UNIT  = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_FAIL  = 5'b10000
  } phase_t;

  // State of one finished string, handed from the parser to the scaler
  typedef struct packed {
    logic                          ok_phase;
    logic [ACC_W-1:0]              accum;
    logic [UNIT_DEPTH-1:0][7:0]    letters;
    logic [1:0]                    count;
  } fin_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ? (c - 8'h20) : c;
  endfunction

endpackage

[rtl/byte_size_string_parser.sv]
// Top level of the byte size string parser: character beats in, one size result per string.
//
//  channel | direction | payload                          | handshake
//  --------+-----------+----------------------------------+---------------------
//  in_     | input     | in_ch[7:0], in_is_last           | in_valid / in_stall
//  out_    | output    | out_size_value[63:0], out_parse_ok | out_valid / out_stall
//
// One character beat is taken every cycle while in_stall is low; the digit step
// (accum*10 + digit) is the only state loop and is computed combinationally.
// A result passes from the input register that takes the string's last beat to the
// scaler register, then to the result register, and shows on out_valid from there.
// Synchronous active-low reset clears the valid bits and the parse state.
// in_stall rises only when a last beat cannot move into a full scaler register.
module byte_size_string_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_size_value,
  output logic        out_parse_ok
);
  import bssp_pkg::*;

  logic fin_valid, fin_ready;
  fin_t fin_data;

  // character parser
  bssp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_is_last(in_is_last),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_ready (fin_ready)
  );

  // unit scaling and result
  bssp_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .fin_valid     (fin_valid),
    .fin_data      (fin_data),
    .fin_ready     (fin_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_size_value(out_size_value),
    .out_parse_ok  (out_parse_ok)
  );

endmodule

[rtl/bssp_core.sv]
// Input register and per-character parse state update (digits, unit letters, spaces).
module bssp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_ch,
  input  logic            in_is_last,
  output logic            fin_valid,
  output bssp_pkg::fin_t  fin_data,
  input  logic            fin_ready
);
  import bssp_pkg::*;

  // input beat register
  logic        s1_v_r;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;

  // parse state
  phase_t                     phase_r, phase_nxt;
  logic [ACC_W-1:0]           accum_r, accum_nxt;
  logic [UNIT_DEPTH-1:0][7:0] let_r, let_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;

  logic        s1_adv, s1_fire;
  logic        c_ws, c_dig, let_wr, dig_ovf;
  logic [ACC_W+3:0] mac;

  // a last beat waits only for room in the scaler; other beats never wait
  always_comb begin
    s1_adv   = !s1_v_r || !s1_last_r || fin_ready;
    s1_fire  = s1_v_r && s1_adv;
    in_stall = !s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_is_last;
    end
  end

  // accum * 10 + digit, overflow when anything lands above bit 63
  always_comb begin
    c_ws    = is_ws(s1_ch_r);
    c_dig   = is_dig(s1_ch_r);
    mac     = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
            + {{(ACC_W){1'b0}}, s1_ch_r[3:0]};
    dig_ovf = |mac[ACC_W+3:ACC_W];
  end

  // phase transitions for one character
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    let_wr    = 1'b0;
    unique case (phase_r)
      PH_LEAD: begin
        if (c_dig) begin
          phase_nxt = dig_ovf ? PH_FAIL : PH_DIGIT;
          accum_nxt = mac[ACC_W-1:0];
        end else if (!c_ws) begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_DIGIT: begin
        if (c_dig) begin
          phase_nxt = dig_ovf ? PH_FAIL : PH_DIGIT;
          accum_nxt = mac[ACC_W-1:0];
        end else if (c_ws) begin
          phase_nxt = PH_TRAIL;
        end else begin
          phase_nxt = PH_UNIT;
          let_wr    = 1'b1;
        end
      end
      PH_UNIT: begin
        if (c_ws) begin
          phase_nxt = PH_TRAIL;
        end else if (c_dig || (cnt_r == 2'd3)) begin
          phase_nxt = PH_FAIL;
        end else begin
          let_wr = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (!c_ws) phase_nxt = PH_FAIL;
      end
      PH_FAIL: phase_nxt = PH_FAIL;
      default: phase_nxt = PH_FAIL;
    endcase
  end

  // unit letter store
  always_comb begin
    for (int i = 0; i < UNIT_DEPTH; i++) begin
      let_nxt[i] = (let_wr && (cnt_r == 2'(i))) ? s1_ch_r : let_r[i];
    end
    cnt_nxt = let_wr ? (cnt_r + 2'd1) : cnt_r;
  end

  // finished string goes to the scaler
  always_comb begin
    fin_valid         = s1_v_r && s1_last_r;
    fin_data.ok_phase = (phase_nxt == PH_DIGIT) || (phase_nxt == PH_UNIT) ||
                        (phase_nxt == PH_TRAIL);
    fin_data.accum    = accum_nxt;
    fin_data.letters  = let_nxt;
    fin_data.count    = cnt_nxt;
  end

  // state register; a last beat returns it to the start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      accum_r <= '0;
      cnt_r   <= 2'd0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        phase_r <= PH_LEAD;
        accum_r <= '0;
        cnt_r   <= 2'd0;
      end else begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) let_r <= let_nxt;
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_last_r && fin_ready) |=> (phase_r == PH_LEAD && cnt_r == 2'd0))
    else $error("parse state not cleared after last beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s1_last_r && !fin_ready))
    else $error("input stalled without a blocked last beat");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FAIL && !(s1_v_r && s1_last_r)) |=> (phase_r == PH_FAIL))
    else $error("failed parse recovered before end of string");
`endif

endmodule

[rtl/bssp_scale.sv]
// Unit suffix decode, binary scaling with overflow check, and the result register.
module bssp_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fin_valid,
  input  bssp_pkg::fin_t  fin_data,
  output logic            fin_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_size_value,
  output logic            out_parse_ok
);
  import bssp_pkg::*;

  typedef enum logic [2:0] {
    SC_NONE, SC_K, SC_M, SC_G, SC_T, SC_P
  } scale_t;

  logic        s2_v_r;
  fin_t        s2_r;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_ok_r;

  logic        out_free, s2_move;
  logic [1:0]  n_eff;
  logic        unit_ok, ovf, good;
  scale_t      sc;
  logic [63:0] val;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    s2_move   = s2_v_r && out_free;
    fin_ready = !s2_v_r || out_free;
  end

  // finished-string register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      s2_v_r <= 1'b1;
    end else if (out_free) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) s2_r <= fin_data;
  end

  // suffix decode: drop a trailing B, then letter with optional I
  always_comb begin
    n_eff   = s2_r.count;
    unit_ok = 1'b1;
    sc      = SC_NONE;
    if (n_eff != 2'd0) begin
      if (upcase(s2_r.letters[n_eff - 2'd1]) == CH_B) n_eff = n_eff - 2'd1;
    end
    case (n_eff)
      2'd0: sc = SC_NONE;
      2'd1, 2'd2: begin
        if ((n_eff == 2'd2) && (upcase(s2_r.letters[1]) != CH_I)) unit_ok = 1'b0;
        case (upcase(s2_r.letters[0]))
          CH_K:    sc = SC_K;
          CH_M:    sc = SC_M;
          CH_G:    sc = SC_G;
          CH_T:    sc = SC_T;
          CH_P:    sc = SC_P;
          default: unit_ok = 1'b0;
        endcase
      end
      default: unit_ok = 1'b0;
    endcase
  end

  // scale by a power of 1024; bits shifted out mean overflow
  always_comb begin
    unique case (sc)
      SC_NONE: begin val = s2_r.accum;                    ovf = 1'b0;                 end
      SC_K:    begin val = {s2_r.accum[53:0], 10'd0};     ovf = |s2_r.accum[63:54];   end
      SC_M:    begin val = {s2_r.accum[43:0], 20'd0};     ovf = |s2_r.accum[63:44];   end
      SC_G:    begin val = {s2_r.accum[33:0], 30'd0};     ovf = |s2_r.accum[63:34];   end
      SC_T:    begin val = {s2_r.accum[23:0], 40'd0};     ovf = |s2_r.accum[63:24];   end
      SC_P:    begin val = {s2_r.accum[13:0], 50'd0};     ovf = |s2_r.accum[63:14];   end
      default: begin val = '0;                            ovf = 1'b1;                 end
    endcase
    good = s2_r.ok_phase && unit_ok && !ovf;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_value_r <= good ? val : 64'd0;
      out_ok_r    <= good;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_size_value = out_value_r;
  assign out_parse_ok   = out_ok_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_value_r == 64'd0))
    else $error("failed parse with nonzero size");

  a_fin_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid && fin_ready) |=> s2_v_r)
    else $error("finished string lost");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    s2_move |=> out_valid_r)
    else $error("result register not loaded");
`endif

endmodule
